// ===== src/pqta_pkg.sv =====
`default_nettype none
package pqta_pkg;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] FUNC_ENQ   = 3'd0;
   localparam logic [2:0] FUNC_DEQ   = 3'd1;
   localparam logic [2:0] FUNC_PLUCK = 3'd2;
   localparam logic [2:0] FUNC_SORT  = 3'd3;
   localparam logic [2:0] FUNC_IDLE  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] PST_READY   = 2'd0;
   localparam logic [1:0] PST_RUNNING = 2'd1;
   localparam logic [1:0] PST_BLOCKED = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [1:0]  st;
      logic [31:0] since;
      logic [31:0] rdy;
      logic [31:0] run;
      logic [31:0] blk;
   } rec_type;
endpackage
`default_nettype wire

// ===== src/process_queue_time_accounting.sv =====
// enqueue writes one record; dequeue and pluck walk the queue and shift later entries down;
// idle walks every record; sort makes up to n bubble passes, n = records held
// one item is in work at a time; the record memory, read through a register,
// is walked one entry at a time
// a result may wait in the output register while the next item is taken
// synchronous reset empties the queue; memory contents are left as they are
`default_nettype none
module process_queue_time_accounting
   import pqta_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_func,
   input  wire logic [15:0]        req_proc_id,
   input  wire logic [1:0]         req_cur_state,
   input  wire logic [31:0]        req_state_since,
   input  wire logic [31:0]        req_ready_in,
   input  wire logic [31:0]        req_run_in,
   input  wire logic [31:0]        req_blocked_in,
   input  wire logic [1:0]         req_target_state,
   input  wire logic [31:0]        req_now,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_out_id,
   output logic [1:0]              rsp_out_state,
   output logic [31:0]             rsp_out_since,
   output logic [31:0]             rsp_out_ready,
   output logic [31:0]             rsp_out_run,
   output logic [31:0]             rsp_out_blocked,
   output logic [4:0]              rsp_count,
   output logic signed [32:0]      rsp_idle_time
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ENQ, S_SCAN, S_SCAN_CHK, S_DEQ_RD, S_DEQ_CAP, S_SH_RD, S_SH_WR,
      S_SO_INIT, S_SO_LD, S_SO_RD, S_SO_WR, S_SO_END, S_DONE
   } fsm_type;

   fsm_type        state_ff;
   logic [CW-1:0]  occ_ff;
   logic [AW-1:0]  idx_ff;
   logic [2:0]     func_ff;
   rec_type        req_ff;
   logic [1:0]     tgt_ff;
   logic [31:0]    now_ff;
   rec_type        carry_ff;
   logic           swapped_ff;
   logic [31:0]    sum_ff;
   logic [31:0]    max_ff;
   logic [1:0]     res_status_ff;
   rec_type        res_rec_ff;
   logic [32:0]    res_idle_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff;
   rec_type        rsp_rec_ff;
   logic [4:0]     rsp_count_ff;
   logic [32:0]    rsp_idle_ff;

   rec_type        mem [QUEUE_DEPTH];
   rec_type        rdata_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   rec_type        wr_data;
   rec_type        enq_rec;
   logic [31:0]    elapsed;
   logic           at_last;
   logic [AW-1:0]  idx_next;
   logic           rsp_free;

   assign idx_next = AW'(idx_ff + 1'b1);
   assign at_last  = (CW'(idx_ff) == CW'(occ_ff - 1'b1));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign elapsed  = now_ff - req_ff.since;

   always_comb begin
      enq_rec = req_ff;
      case (req_ff.st)
         PST_READY:   enq_rec.rdy = req_ff.rdy + elapsed;
         PST_RUNNING: enq_rec.run = req_ff.run + elapsed;
         PST_BLOCKED: enq_rec.blk = req_ff.blk + elapsed;
         default:     enq_rec = req_ff;
      endcase
      enq_rec.st    = tgt_ff;
      enq_rec.since = now_ff;
   end

   always_comb begin
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rdata_ff;
      case (state_ff)
         S_ENQ: begin
            wr_en   = 1'b1;
            wr_addr = AW'(occ_ff);
            wr_data = enq_rec;
         end
         S_DEQ_RD, S_SO_INIT: rd_addr = '0;
         S_SH_RD, S_SO_RD:    rd_addr = idx_next;
         S_SH_WR:             wr_en = 1'b1;
         S_SO_WR: begin
            wr_en   = 1'b1;
            wr_data = (carry_ff.id > rdata_ff.id) ? rdata_ff : carry_ff;
         end
         S_SO_END: begin
            wr_en   = 1'b1;
            wr_data = carry_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff       <= req_func;
                  req_ff        <= '{req_proc_id, req_cur_state, req_state_since,
                                     req_ready_in, req_run_in, req_blocked_in};
                  tgt_ff        <= req_target_state;
                  now_ff        <= req_now;
                  res_status_ff <= STATUS_OK;
                  res_rec_ff    <= '0;
                  res_idle_ff   <= '0;
                  idx_ff        <= '0;
                  sum_ff        <= '0;
                  max_ff        <= '0;
                  state_ff      <= S_DONE;
                  case (req_func)
                     FUNC_ENQ: begin
                        if (occ_ff == CW'(QUEUE_DEPTH)) begin
                           res_status_ff <= STATUS_FULL;
                        end else begin
                           state_ff <= S_ENQ;
                        end
                     end
                     FUNC_DEQ: begin
                        if (occ_ff == '0) begin
                           res_status_ff <= STATUS_EMPTY;
                        end else begin
                           state_ff <= S_DEQ_RD;
                        end
                     end
                     FUNC_PLUCK: begin
                        if (occ_ff == '0) begin
                           res_status_ff <= STATUS_EMPTY;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     FUNC_SORT: begin
                        if (occ_ff > CW'(1)) begin
                           state_ff <= S_SO_INIT;
                        end
                     end
                     FUNC_IDLE: begin
                        if (occ_ff != '0) begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_ENQ: begin
               occ_ff   <= occ_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_SCAN: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (func_ff == FUNC_PLUCK) begin
                  if (rdata_ff.id == req_ff.id) begin
                     res_rec_ff <= rdata_ff;
                     state_ff   <= S_SH_RD;
                  end else if (at_last) begin
                     res_status_ff <= STATUS_EMPTY;
                     state_ff      <= S_DONE;
                  end else begin
                     idx_ff   <= idx_next;
                     state_ff <= S_SCAN;
                  end
               end else begin
                  sum_ff <= sum_ff + rdata_ff.run;
                  if (rdata_ff.since > max_ff) begin
                     max_ff <= rdata_ff.since;
                  end
                  if (at_last) begin
                     state_ff <= S_DONE;
                     res_idle_ff <= {1'b0, ((rdata_ff.since > max_ff) ? rdata_ff.since
                                            : max_ff)} - {1'b0, sum_ff + rdata_ff.run};
                  end else begin
                     idx_ff   <= idx_next;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_DEQ_RD: state_ff <= S_DEQ_CAP;
            S_DEQ_CAP: begin
               res_rec_ff <= rdata_ff;
               state_ff   <= S_SH_RD;
            end
            // close the gap one entry at a time
            S_SH_RD: begin
               if (at_last) begin
                  occ_ff   <= occ_ff - 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SH_WR;
               end
            end
            S_SH_WR: begin
               idx_ff   <= idx_next;
               state_ff <= S_SH_RD;
            end
            // bubble pass: carry holds the larger id so far
            S_SO_INIT: begin
               idx_ff     <= '0;
               swapped_ff <= 1'b0;
               state_ff   <= S_SO_LD;
            end
            S_SO_LD: begin
               carry_ff <= rdata_ff;
               state_ff <= S_SO_RD;
            end
            S_SO_RD: state_ff <= S_SO_WR;
            S_SO_WR: begin
               if (carry_ff.id > rdata_ff.id) begin
                  swapped_ff <= 1'b1;
               end else begin
                  carry_ff <= rdata_ff;
               end
               idx_ff <= idx_next;
               if (CW'(idx_next) == CW'(occ_ff - 1'b1)) begin
                  state_ff <= S_SO_END;
               end else begin
                  state_ff <= S_SO_RD;
               end
            end
            S_SO_END: state_ff <= swapped_ff ? S_SO_INIT : S_DONE;
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_rec_ff    <= res_rec_ff;
                  rsp_count_ff  <= 5'(occ_ff);
                  rsp_idle_ff   <= res_idle_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_rec_ff.id;
   assign rsp_out_state   = rsp_rec_ff.st;
   assign rsp_out_since   = rsp_rec_ff.since;
   assign rsp_out_ready   = rsp_rec_ff.rdy;
   assign rsp_out_run     = rsp_rec_ff.run;
   assign rsp_out_blocked = rsp_rec_ff.blk;
   assign rsp_count       = rsp_count_ff;
   assign rsp_idle_time   = $signed(rsp_idle_ff);

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");
   a_shift_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_RD || state_ff == S_SCAN) |-> CW'(idx_ff) < occ_ff)
      else $error("walk index past occupancy");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished item not presented");
   a_occ_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(occ_ff))
      else $error("occupancy moved while idle");
`endif
endmodule
`default_nettype wire
